FILE: rtl/core/fwm_pkg.sv
// Shared types and constants for the file name wildcard matcher.
package fwm_pkg;

    localparam int unsigned PAT_MAX   = 16;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned DATA_W    = 64;
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned REG_IDX_W = 2;

    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_QUEST = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

    localparam logic [REG_IDX_W-1:0] REG_CHARS_LO = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHARS_HI = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LENGTH   = 2'd2;

    typedef struct packed {
        logic                 char_step;
        logic                 end_step;
        logic                 cfg_wr;
        logic [REG_IDX_W-1:0] cfg_idx;
    } cmd_t;

endpackage

FILE: rtl/core/fwm_ctrl.sv
// Handshake controller: accepts beats, issues datapath commands, owns the result slot.
module fwm_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          name_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fwm_pkg::ADDR_W-1:0]    paddr,
    output fwm_pkg::cmd_t                 cmd
);

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    logic state_reg;
    logic state_next;
    logic in_accept;

    assign in_stall  = (state_reg == ST_FULL) && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = (state_reg == ST_FULL);

    always_comb
    begin
        cmd.char_step = in_accept && !name_end;
        cmd.end_step  = in_accept && name_end;
        cmd.cfg_wr    = psel && penable && pwrite;
        cmd.cfg_idx   = paddr[fwm_pkg::ADDR_W-1:fwm_pkg::ADDR_W-fwm_pkg::REG_IDX_W];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY:
            begin
                if (cmd.end_step)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (cmd.end_step)
                begin
                    state_next = ST_FULL;
                end
                else if (!out_stall)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_end_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.end_step |=> out_valid)
        else $error("Result slot not filled after an end beat.");

    a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !(cmd.char_step || cmd.end_step))
        else $error("Beat accepted while the result slot is blocked.");

    a_slot_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !cmd.end_step) |=> !out_valid)
        else $error("Result slot did not drain after a taken result.");
`endif

endmodule

FILE: rtl/core/fwm_datapath.sv
// Pattern registers, match position tracking and result register.
module fwm_datapath
#(
    parameter int unsigned PATTERN_CHARS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fwm_pkg::cmd_t                 cmd,
    input  logic [fwm_pkg::CHAR_W-1:0]    name_char,
    input  logic [fwm_pkg::DATA_W-1:0]    pwdata,
    output logic [fwm_pkg::DATA_W-1:0]    prdata,
    output logic                          matched
);

    localparam int unsigned PM  = fwm_pkg::PAT_MAX;
    localparam int unsigned PW  = fwm_pkg::POS_W;
    localparam int unsigned CW  = fwm_pkg::CHAR_W;
    localparam logic [PW-1:0] LEN_CAP = PW'(PATTERN_CHARS);

    logic [fwm_pkg::DATA_W-1:0] chars_lo_reg;
    logic [fwm_pkg::DATA_W-1:0] chars_hi_reg;
    logic [PW-1:0]              length_reg;
    logic [PW-1:0]              pos_reg;
    logic [PW-1:0]              pos_next;
    logic                       failed_reg;
    logic                       failed_next;
    logic                       matched_reg;

    logic [2*fwm_pkg::DATA_W-1:0] chars_all;
    logic [CW-1:0]                pchar [PM];
    logic [PM-1:0]                in_use;
    logic [PM-1:0]                is_wild;
    logic [PM-1:0]                tail_ok;
    logic [PM-1:0]                dot_stop;
    logic [PW-1:0]                len_eff;
    logic                         nz_run;
    logic [PW-2:0]                pos_idx;
    logic                         pos_ok;
    logic [CW-1:0]                cur;
    logic [PW-2:0]                stop_idx;
    logic                         stop_found;
    logic                         end_ok;

    assign chars_all = {chars_hi_reg, chars_lo_reg};
    assign len_eff   = (length_reg > LEN_CAP) ? LEN_CAP : length_reg;
    assign pos_idx   = pos_reg[PW-2:0];
    assign pos_ok    = !pos_reg[PW-1] && in_use[pos_idx];
    assign cur       = pchar[pos_idx];
    assign matched   = matched_reg;

    always_comb
    begin
        nz_run = 1'b1;
        for (int i = 0; i < PM; i++)
        begin
            pchar[i]   = chars_all[CW*i +: CW];
            nz_run     = nz_run && (pchar[i] != '0);
            in_use[i]  = nz_run && (PW'(i) < len_eff);
            is_wild[i] = (pchar[i] == fwm_pkg::CH_STAR) || (pchar[i] == fwm_pkg::CH_QUEST);
            dot_stop[i] = (PW'(i) >= pos_reg) && (!in_use[i] || !is_wild[i]);
            tail_ok[i] = !(PW'(i) >= pos_reg) || !in_use[i] || is_wild[i]
                         || (pchar[i] == fwm_pkg::CH_DOT);
        end
    end

    always_comb
    begin
        stop_idx   = '0;
        stop_found = 1'b0;
        for (int j = PM - 1; j >= 0; j--)
        begin
            if (dot_stop[j])
            begin
                stop_idx   = (PW-1)'(j);
                stop_found = 1'b1;
            end
        end
    end

    assign end_ok = !failed_reg && (&tail_ok);

    always_comb
    begin
        pos_next    = pos_reg;
        failed_next = failed_reg;
        if (cmd.end_step)
        begin
            pos_next    = '0;
            failed_next = 1'b0;
        end
        else if (cmd.char_step && !failed_reg)
        begin
            priority if (!pos_ok)
            begin
                failed_next = 1'b1;
            end
            else if (name_char == cur)
            begin
                pos_next = pos_reg + PW'(1);
            end
            else if (name_char == fwm_pkg::CH_DOT)
            begin
                if (stop_found && in_use[stop_idx] && (pchar[stop_idx] == fwm_pkg::CH_DOT))
                begin
                    pos_next = PW'(stop_idx) + PW'(1);
                end
                else
                begin
                    failed_next = 1'b1;
                end
            end
            else if (cur == fwm_pkg::CH_STAR)
            begin
                pos_next = pos_reg;
            end
            else if (cur == fwm_pkg::CH_QUEST)
            begin
                pos_next = pos_reg + PW'(1);
            end
            else
            begin
                failed_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (cmd.cfg_idx)
            fwm_pkg::REG_CHARS_LO: prdata = chars_lo_reg;
            fwm_pkg::REG_CHARS_HI: prdata = chars_hi_reg;
            fwm_pkg::REG_LENGTH:   prdata = fwm_pkg::DATA_W'(length_reg);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_lo_reg <= '0;
            chars_hi_reg <= '0;
            length_reg   <= '0;
            pos_reg      <= '0;
            failed_reg   <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            failed_reg <= failed_next;
            if (cmd.cfg_wr)
            begin
                unique case (cmd.cfg_idx)
                    fwm_pkg::REG_CHARS_LO: chars_lo_reg <= pwdata;
                    fwm_pkg::REG_CHARS_HI: chars_hi_reg <= pwdata;
                    fwm_pkg::REG_LENGTH:   length_reg   <= pwdata[PW-1:0];
                    default:               length_reg   <= length_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.end_step)
        begin
            matched_reg <= end_ok;
        end
    end

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.end_step |=> (pos_reg == '0) && !failed_reg)
        else $error("Match state not cleared after an end beat.");

    a_fail_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (failed_reg && !cmd.end_step) |=> failed_reg && $stable(pos_reg))
        else $error("Failure cleared or position moved before the end beat.");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LEN_CAP)
        else $error("Pattern position beyond the pattern bound.");
`endif

endmodule

FILE: rtl/core/filename_wildcard_matcher_core.sv
// Top level of the file name wildcard matcher.
// The result beat is presented in the cycle after its end beat is accepted.
// Throughput: one name beat per cycle unless the result slot is blocked; the pattern
// compare and a find-first encoder over the pattern positions resolve each beat.
// Reset clears the pattern registers, the match position and the result slot at once.
module filename_wildcard_matcher_core
#(
    parameter int unsigned PATTERN_CHARS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fwm_pkg::CHAR_W-1:0]    name_char,
    input  logic                          name_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          matched,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fwm_pkg::ADDR_W-1:0]    paddr,
    input  logic [fwm_pkg::DATA_W-1:0]    pwdata,
    output logic [fwm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    fwm_pkg::cmd_t cmd;

    assign pready = 1'b1;

    fwm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .name_end  (name_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .cmd       (cmd)
    );

    fwm_datapath #(
        .PATTERN_CHARS (PATTERN_CHARS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .name_char (name_char),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .matched   (matched)
    );

endmodule

FILE: sim/filename_wildcard_matcher_core_test.sv
// Self-checking testbench for the file name wildcard matcher core.
module filename_wildcard_matcher_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PAT_MAX   = fwm_pkg::PAT_MAX;
    localparam int unsigned POS_W     = fwm_pkg::POS_W;
    localparam int unsigned CHAR_W    = fwm_pkg::CHAR_W;
    localparam int unsigned DATA_W    = fwm_pkg::DATA_W;
    localparam int unsigned ADDR_W    = fwm_pkg::ADDR_W;
    localparam int unsigned REG_IDX_W = fwm_pkg::REG_IDX_W;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [CHAR_W-1:0]   name_char = '0;
    logic                name_end = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                matched;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    logic [DATA_W-1:0]   pat_lo = '0;
    logic [DATA_W-1:0]   pat_hi = '0;
    logic [POS_W-1:0]    pat_len = '0;
    logic [POS_W-1:0]    pat_pos = '0;
    logic                pat_failed = 1'b0;
    logic                match_q[$];
    logic                expected_match;

    int errors = 0;
    int beats_sent = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;

    filename_wildcard_matcher_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .name_char (name_char),
        .name_end  (name_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .matched   (matched),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    function automatic logic [CHAR_W-1:0] pattern_byte(input int i);
        logic [2*DATA_W-1:0] chars;
        chars = {pat_hi, pat_lo};
        return chars[8*i +: 8];
    endfunction

    function automatic int active_len();
        int n;
        n = (pat_len > PAT_MAX) ? PAT_MAX : pat_len;
        for (int i = 0; i < n; i++)
        begin
            if (pattern_byte(i) == '0)
                return i;
        end
        return n;
    endfunction

    function automatic void match_name_step(input logic [CHAR_W-1:0] c, input logic last);
        int len;
        int pos;
        logic [CHAR_W-1:0] p;
        logic ok;
        len = active_len();
        pos = pat_pos;
        if (last)
        begin
            ok = !pat_failed;
            while (ok && pos < len)
            begin
                p = pattern_byte(pos);
                if (p != fwm_pkg::CH_STAR && p != fwm_pkg::CH_QUEST && p != fwm_pkg::CH_DOT)
                    ok = 1'b0;
                pos++;
            end
            match_q.push_back(ok);
            pat_pos = '0;
            pat_failed = 1'b0;
        end
        else if (!pat_failed)
        begin
            if (pos >= len)
                pat_failed = 1'b1;
            else
            begin
                p = pattern_byte(pos);
                if (c == p)
                    pos++;
                else if (c == fwm_pkg::CH_DOT)
                begin
                    while (pos < len && (pattern_byte(pos) == fwm_pkg::CH_STAR ||
                                         pattern_byte(pos) == fwm_pkg::CH_QUEST))
                        pos++;
                    if (pos < len && pattern_byte(pos) == fwm_pkg::CH_DOT)
                        pos++;
                    else
                        pat_failed = 1'b1;
                end
                else if (p == fwm_pkg::CH_QUEST)
                    pos++;
                else if (p != fwm_pkg::CH_STAR)
                    pat_failed = 1'b1;
                pat_pos = pos[POS_W-1:0];
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            match_name_step(name_char, name_end);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (match_q.size() == 0)
            begin
                $error("matched: unexpected result beat, actual %0b", matched);
                errors++;
            end
            else
            begin
                expected_match = match_q.pop_front();
                if (matched !== expected_match)
                begin
                    $error("matched: expected %0b, actual %0b", expected_match, matched);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic send_beat(input logic [CHAR_W-1:0] c, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        name_char <= c;
        name_end <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic send_text(input string s, input logic finish);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
        if (finish)
            send_beat(CHAR_W'($urandom), 1'b1);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (match_q.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            fwm_pkg::REG_CHARS_LO: pat_lo = val;
            fwm_pkg::REG_CHARS_HI: pat_hi = val;
            default:               pat_len = val[POS_W-1:0];
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_pattern(input logic [2*DATA_W-1:0] chars, input int unsigned len);
        wait_idle();
        write_reg(fwm_pkg::REG_CHARS_LO, chars[DATA_W-1:0]);
        write_reg(fwm_pkg::REG_CHARS_HI, chars[2*DATA_W-1:DATA_W]);
        write_reg(fwm_pkg::REG_LENGTH, DATA_W'(len));
    endtask

    function automatic logic [2*DATA_W-1:0] pack_text(input string s);
        logic [2*DATA_W-1:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < PAT_MAX; i++)
            v[8*i +: 8] = s[i];
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] random_letter();
        if ($urandom_range(0, 9) != 0)
            return CHAR_W'("A") + CHAR_W'($urandom_range(0, 3));
        return CHAR_W'($urandom);
    endfunction

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        send_beat(CHAR_W'($urandom), 1'b1);
        write_pattern(pack_text("F?*.TX"), 6);
        send_beat("F", 1'b0);
        send_beat(8'h00, 1'b0);
        send_text("ZZ.TX", 1'b1);
        write_pattern({{8{"A"}}, 64'h00FF}, 31);
        send_beat(8'hFF, 1'b0);
        send_beat(CHAR_W'($urandom), 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h01, 1'b0);
        send_beat(8'h02, 1'b0);
        send_beat(CHAR_W'($urandom), 1'b1);
        write_pattern({64'h5A2A2A2A2A2A2A2A, {8{"*"}}}, 31);
        send_beat(CHAR_W'($urandom), 1'b1);
        write_pattern(pack_text("AB"), 2);
        send_beat("A", 1'b0);
        write_pattern(pack_text("AC"), 2);
        send_text("C", 1'b1);
        write_pattern(pack_text("*X"), 2);
        send_text(".", 1'b1);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        write_pattern(pack_text("*"), 1);
        hold_req = 200;
        repeat (40)
        begin
            send_beat("A", 1'b0);
            send_beat(CHAR_W'($urandom), 1'b1);
        end
    endtask

    task automatic send_random_name();
        logic [CHAR_W-1:0] text[$];
        logic [CHAR_W-1:0] p;
        int len;
        int kind;
        len = active_len();
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            repeat ($urandom_range(0, 6)) text.push_back(CHAR_W'($urandom));
        end
        else
        begin
            for (int i = 0; i < len; i++)
            begin
                p = pattern_byte(i);
                if (p == fwm_pkg::CH_STAR)
                    repeat ($urandom_range(0, 2)) text.push_back(random_letter());
                else if (p == fwm_pkg::CH_QUEST)
                    text.push_back(random_letter());
                else
                    text.push_back(p);
            end
            if (kind >= 80 && text.size() > 0)
                text[$urandom_range(0, text.size() - 1)] = CHAR_W'($urandom);
            else if (kind >= 70 && text.size() > 0)
                text.delete($urandom_range(0, text.size() - 1));
            else if (kind >= 60)
                text.push_back(random_letter());
        end
        foreach (text[i])
            send_beat(text[i], 1'b0);
        send_beat(CHAR_W'($urandom), 1'b1);
    endtask

    task automatic test_random(input int idle_pct, input int recv_pct, input int count);
        logic [2*DATA_W-1:0] chars;
        int start;
        int r;
        send_idle_pct = idle_pct;
        stall_pct = recv_pct;
        start = beats_sent;
        while (beats_sent - start < count)
        begin
            for (int i = 0; i < PAT_MAX; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                    chars[8*i +: 8] = fwm_pkg::CH_STAR;
                else if (r < 50)
                    chars[8*i +: 8] = fwm_pkg::CH_QUEST;
                else if (r < 62)
                    chars[8*i +: 8] = fwm_pkg::CH_DOT;
                else if (r < 92)
                    chars[8*i +: 8] = CHAR_W'("A") + CHAR_W'($urandom_range(0, 3));
                else if (r < 98)
                    chars[8*i +: 8] = CHAR_W'($urandom_range(1, 255));
                else
                    chars[8*i +: 8] = '0;
            end
            if ($urandom_range(0, 4) == 0)
                write_pattern(chars, $urandom_range(0, 31));
            else
                write_pattern(chars, $urandom_range(0, PAT_MAX));
            repeat ($urandom_range(4, 12)) send_random_name();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        test_random(10, 51, 240);
        test_random(51, 10, 240);
        test_random(0, 0, 240);
        wait_idle();
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
